### hw/rtl/swft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swft_pkg: shared types and constants
// Table geometry, row layout, controller states and the punctuation test.
// ----------------------------------------------------------------------------

package swft_pkg;

  localparam int DictEntries = 1024;
  localparam int WordBytes   = 20;
  // the last byte of a stored word is always the terminator, so it is not kept
  localparam int KeyBytes    = WordBytes - 1;
  localparam int KeyW        = KeyBytes * 8;
  localparam int IdxW        = 10;
  localparam int UsedW       = 11;
  localparam int CountW      = 32;
  localparam int LenW        = 5;

  localparam logic CmdChar = 1'b0;
  localparam logic CmdRead = 1'b1;

  // byte 0 of a word sits in the top byte so that keys compare as numbers
  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    key_t              key;
    logic [CountW-1:0] cnt;
  } row_t;

  typedef enum logic [3:0] {
    StIdle,
    StSrch,
    StCmp,
    StDecide,
    StShRd,
    StShWr,
    StIns,
    StRdWait,
    StRdEmit,
    StRdDrop
  } state_e;

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {[8'h21:8'h2f], [8'h3a:8'h40], [8'h5b:8'h60], [8'h7b:8'h7e]};
  endfunction

endpackage

### hw/rtl/sorted_word_frequency_table.sv
`timescale 1ns / 1ps
// Word character: accepted while idle, and the block stays ready.
// End of word: a binary search with one table read per step (StSrch, then StCmp),
// plus a read and a write per moved entry on insertion, through the single port pair.
// Read: one result per cycle while out_ready_i holds, per stored byte and a last one.
// Reset clears control state and the word count only; the table needs no clearing pass.
// ----------------------------------------------------------------------------
// sorted_word_frequency_table
// Sorted word table with occurrence counts, held in one synchronous memory.
// ----------------------------------------------------------------------------

module sorted_word_frequency_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [7:0]                  char_in_i,
  input  logic                        end_of_word_i,
  input  logic [swft_pkg::IdxW-1:0]   entry_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  char_out_o,
  output logic [swft_pkg::CountW-1:0] count_o,
  output logic [swft_pkg::IdxW-1:0]   position_o,
  output logic                        new_word_o,
  output logic                        dropped_o,
  output logic [swft_pkg::UsedW-1:0]  entries_in_use_o,
  output logic                        last_o
);

  localparam int KeyW     = swft_pkg::KeyW;
  localparam int KeyBytes = swft_pkg::KeyBytes;
  localparam int IdxW     = swft_pkg::IdxW;
  localparam int UsedW    = swft_pkg::UsedW;
  localparam int CountW   = swft_pkg::CountW;
  localparam int LenW     = swft_pkg::LenW;

  swft_pkg::state_e state_q, state_d;
  logic [UsedW-1:0]  lo_q, lo_d, hi_q, hi_d, used_q, used_d;
  logic              found_q, found_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  swft_pkg::key_t    key_q, key_d, buf_q, buf_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [LenW-1:0]   bi_q, bi_d, wlen_q, wlen_d, klen_q, klen_d;
  logic              zseen_q, zseen_d;
  logic [7:0]        lastc_q, lastc_d;

  // table memory
  swft_pkg::row_t mem [swft_pkg::DictEntries];
  swft_pkg::row_t rd_q, mem_wd;
  logic           mem_re, mem_we;
  logic [IdxW-1:0] mem_ra, mem_wa;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // word assembly
  logic [7:0]      ch_l, wbyte;
  swft_pkg::key_t  buf_n, key_n;
  logic [LenW-1:0] wlen_n, klen_n;
  logic            z_n;
  logic [7:0]      last_n;

  always_comb begin
    ch_l   = char_in_i inside {[8'h41:8'h5a]} ? char_in_i + 8'd32 : char_in_i;
    wbyte  = zseen_q ? 8'd0 : ch_l;
    buf_n  = buf_q;
    wlen_n = wlen_q;
    klen_n = klen_q;
    z_n    = zseen_q;
    last_n = lastc_q;
    if (wlen_q < LenW'(KeyBytes)) begin
      for (int i = 0; i < KeyBytes; i++) begin
        if (wlen_q == LenW'(i)) begin
          buf_n[KeyW-1-8*i -: 8] = wbyte;
        end
      end
      wlen_n = wlen_q + 1'b1;
      if (!zseen_q) begin
        if (ch_l == 8'd0) begin
          z_n = 1'b1;
        end else begin
          klen_n = klen_q + 1'b1;
          last_n = ch_l;
        end
      end
    end
    // drop one trailing punctuation byte
    key_n = buf_n;
    if (klen_n != '0 && swft_pkg::is_punct(last_n)) begin
      for (int i = 0; i < KeyBytes; i++) begin
        if (klen_n == LenW'(i + 1)) begin
          key_n[KeyW-1-8*i -: 8] = 8'd0;
        end
      end
    end
  end

  // read-back byte select
  logic [7:0] rd_byte;
  always_comb begin
    rd_byte = 8'd0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (bi_q == LenW'(i)) begin
        rd_byte = rd_q.key[KeyW-1-8*i -: 8];
      end
    end
  end

  logic [UsedW:0]    mid_sum;
  logic [UsedW-1:0]  mid;
  logic [CountW-1:0] cnt_inc;
  logic              out_free, emit;
  logic [7:0]        e_char;
  logic [CountW-1:0] e_cnt;
  logic [IdxW-1:0]   e_pos;
  logic              e_new, e_drop, e_last;
  logic [UsedW-1:0]  e_used;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[UsedW:1];
  assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign out_free = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == swft_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    used_d  = used_q;
    found_d = found_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    ptr_d   = ptr_q;
    bi_d    = bi_q;
    buf_d   = buf_q;
    wlen_d  = wlen_q;
    klen_d  = klen_q;
    zseen_d = zseen_q;
    lastc_d = lastc_q;
    mem_re  = 1'b0;
    mem_ra  = ptr_q;
    mem_we  = 1'b0;
    mem_wa  = ptr_q;
    mem_wd  = rd_q;
    emit    = 1'b0;
    e_char  = 8'd0;
    e_cnt   = '0;
    e_pos   = '0;
    e_new   = 1'b0;
    e_drop  = 1'b0;
    e_last  = 1'b1;
    e_used  = used_q;

    case (state_q)
      swft_pkg::StIdle: begin
        if (in_valid_i) begin
          if (command_i == swft_pkg::CmdRead) begin
            if ({1'b0, entry_index_i} >= used_q) begin
              state_d = swft_pkg::StRdDrop;
            end else begin
              mem_re  = 1'b1;
              mem_ra  = entry_index_i;
              ptr_d   = entry_index_i;
              state_d = swft_pkg::StRdWait;
            end
          end else if (end_of_word_i) begin
            key_d   = key_n;
            buf_d   = '0;
            wlen_d  = '0;
            klen_d  = '0;
            zseen_d = 1'b0;
            lo_d    = '0;
            hi_d    = used_q;
            found_d = 1'b0;
            state_d = swft_pkg::StSrch;
          end else begin
            buf_d   = buf_n;
            wlen_d  = wlen_n;
            klen_d  = klen_n;
            zseen_d = z_n;
            lastc_d = last_n;
          end
        end
      end
      swft_pkg::StSrch: begin
        if (lo_q < hi_q) begin
          mem_re  = 1'b1;
          mem_ra  = mid[IdxW-1:0];
          ptr_d   = mid[IdxW-1:0];
          state_d = swft_pkg::StCmp;
        end else begin
          state_d = swft_pkg::StDecide;
        end
      end
      swft_pkg::StCmp: begin
        if (rd_q.key < key_q) begin
          lo_d = {1'b0, ptr_q} + 1'b1;
        end else begin
          hi_d = {1'b0, ptr_q};
        end
        // keys are unique, so a hit can only be the final position
        if (rd_q.key == key_q) begin
          found_d = 1'b1;
          cnt_d   = rd_q.cnt;
        end
        state_d = swft_pkg::StSrch;
      end
      swft_pkg::StDecide: begin
        if (found_q) begin
          if (out_free) begin
            mem_we  = 1'b1;
            mem_wa  = lo_q[IdxW-1:0];
            mem_wd  = '{key: key_q, cnt: cnt_inc};
            emit    = 1'b1;
            e_cnt   = cnt_inc;
            e_pos   = lo_q[IdxW-1:0];
            state_d = swft_pkg::StIdle;
          end
        end else if (used_q == UsedW'(swft_pkg::DictEntries)) begin
          if (out_free) begin
            emit    = 1'b1;
            e_drop  = 1'b1;
            state_d = swft_pkg::StIdle;
          end
        end else if (used_q > lo_q) begin
          ptr_d   = IdxW'(used_q - 1'b1);
          state_d = swft_pkg::StShRd;
        end else begin
          state_d = swft_pkg::StIns;
        end
      end
      swft_pkg::StShRd: begin
        mem_re  = 1'b1;
        mem_ra  = ptr_q;
        state_d = swft_pkg::StShWr;
      end
      swft_pkg::StShWr: begin
        mem_we = 1'b1;
        mem_wa = ptr_q + 1'b1;
        mem_wd = rd_q;
        if ({1'b0, ptr_q} == lo_q) begin
          state_d = swft_pkg::StIns;
        end else begin
          ptr_d   = ptr_q - 1'b1;
          state_d = swft_pkg::StShRd;
        end
      end
      swft_pkg::StIns: begin
        if (out_free) begin
          mem_we  = 1'b1;
          mem_wa  = lo_q[IdxW-1:0];
          mem_wd  = '{key: key_q, cnt: CountW'(1)};
          used_d  = used_q + 1'b1;
          emit    = 1'b1;
          e_cnt   = CountW'(1);
          e_pos   = lo_q[IdxW-1:0];
          e_new   = 1'b1;
          e_used  = used_q + 1'b1;
          state_d = swft_pkg::StIdle;
        end
      end
      swft_pkg::StRdWait: begin
        bi_d    = '0;
        state_d = swft_pkg::StRdEmit;
      end
      swft_pkg::StRdEmit: begin
        if (out_free) begin
          emit  = 1'b1;
          e_cnt = rd_q.cnt;
          e_pos = ptr_q;
          if (bi_q < LenW'(KeyBytes) && rd_byte != 8'd0) begin
            e_char = rd_byte;
            e_last = 1'b0;
            bi_d   = bi_q + 1'b1;
          end else begin
            state_d = swft_pkg::StIdle;
          end
        end
      end
      swft_pkg::StRdDrop: begin
        if (out_free) begin
          emit    = 1'b1;
          e_drop  = 1'b1;
          state_d = swft_pkg::StIdle;
        end
      end
      default: begin
        state_d = swft_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swft_pkg::StIdle;
      used_q      <= '0;
      wlen_q      <= '0;
      klen_q      <= '0;
      zseen_q     <= 1'b0;
      buf_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      wlen_q  <= wlen_d;
      klen_q  <= klen_d;
      zseen_q <= zseen_d;
      buf_q   <= buf_d;
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    cnt_q   <= cnt_d;
    key_q   <= key_d;
    ptr_q   <= ptr_d;
    bi_q    <= bi_d;
    lastc_q <= lastc_d;
    if (emit) begin
      char_out_o       <= e_char;
      count_o          <= e_cnt;
      position_o       <= e_pos;
      new_word_o       <= e_new;
      dropped_o        <= e_drop;
      entries_in_use_o <= e_used;
      last_o           <= e_last;
    end
  end

  // search window never inverts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swft_pkg::StSrch || state_q == swft_pkg::StCmp) |-> lo_q <= hi_q)
    else $error("search window inverted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(swft_pkg::DictEntries))
    else $error("word count beyond table size");

  // an insertion only happens with room left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == swft_pkg::StIns |-> used_q < UsedW'(swft_pkg::DictEntries))
    else $error("insertion into full table");

  // shifting never moves below the insertion point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == swft_pkg::StShWr |-> {1'b0, ptr_q} >= lo_q)
    else $error("shift ran past insertion point");

  // a new result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result overwritten before transfer");

endmodule

### verif/sorted_word_frequency_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_word_frequency_table_tb: self-checking testbench
// Feeds words byte by byte and read-back commands through the input channel,
// predicts the sorted table and its counts, and checks every output transfer.
// ----------------------------------------------------------------------------

module sorted_word_frequency_table_tb;

  typedef struct {
    logic                      cmd;
    logic [7:0]                ch;
    logic                      eow;
    logic [swft_pkg::IdxW-1:0] idx;
  } item_t;

  typedef struct {
    logic [7:0]                  ch;
    logic [swft_pkg::CountW-1:0] cnt;
    logic [swft_pkg::IdxW-1:0]   pos;
    logic                        nw;
    logic                        dr;
    logic [swft_pkg::UsedW-1:0]  used;
    logic                        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = swft_pkg::CmdChar;
  logic [7:0] char_in_i = 8'h00;
  logic end_of_word_i = 1'b0;
  logic [swft_pkg::IdxW-1:0] entry_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] char_out_o;
  logic [swft_pkg::CountW-1:0] count_o;
  logic [swft_pkg::IdxW-1:0] position_o;
  logic new_word_o;
  logic dropped_o;
  logic [swft_pkg::UsedW-1:0] entries_in_use_o;
  logic last_o;

  sorted_word_frequency_table dut (.*);

  always #5 clk_i = ~clk_i;

  item_t pending_items[$];
  res_t  expected_results[$];
  int    mismatches = 0;
  logic  in_fire = 1'b0;
  logic  quiet = 1'b1;
  logic  stall_req = 1'b0;
  logic  stall_done = 1'b0;
  int    stall_left = 0;

  // predicted table state
  swft_pkg::key_t              table_keys[swft_pkg::DictEntries];
  logic [swft_pkg::CountW-1:0] table_counts[swft_pkg::DictEntries];
  int                          table_used = 0;
  logic [7:0]                  word_bytes[swft_pkg::KeyBytes];
  int                          word_len = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic res_t mk(input logic [7:0] ch, input logic [31:0] cnt, input int pos,
                              input logic nw, input logic dr, input logic last);
    res_t r;
    r.ch = ch; r.cnt = cnt; r.pos = pos[swft_pkg::IdxW-1:0]; r.nw = nw; r.dr = dr;
    r.used = table_used[swft_pkg::UsedW-1:0]; r.last = last;
    return r;
  endfunction

  task automatic predict_transfer(input item_t it);
    swft_pkg::key_t key;
    logic [7:0] c;
    int len, lo, hi, mid;
    if (it.cmd == swft_pkg::CmdRead) begin
      if (it.idx >= table_used) begin
        expected_results.push_back(mk(8'h00, 0, 0, 1'b0, 1'b1, 1'b1));
      end else begin
        key = table_keys[it.idx];
        for (int i = 0; i < swft_pkg::KeyBytes; i++) begin
          c = key[swft_pkg::KeyW-1-8*i -: 8];
          if (c == 8'h00) break;
          expected_results.push_back(mk(c, table_counts[it.idx], it.idx, 1'b0, 1'b0, 1'b0));
        end
        expected_results.push_back(mk(8'h00, table_counts[it.idx], it.idx, 1'b0, 1'b0, 1'b1));
      end
      return;
    end
    c = it.ch;
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    if (word_len < swft_pkg::KeyBytes) begin
      word_bytes[word_len] = c;
      word_len++;
    end
    if (!it.eow) return;
    // a zero byte ends the key; everything after it is cleared
    key = '0;
    len = 0;
    while (len < word_len && word_bytes[len] != 8'h00) begin
      key[swft_pkg::KeyW-1-8*len -: 8] = word_bytes[len];
      len++;
    end
    word_len = 0;
    if (len > 0 && swft_pkg::is_punct(key[swft_pkg::KeyW-1-8*(len-1) -: 8]))
      key[swft_pkg::KeyW-1-8*(len-1) -: 8] = 8'h00;
    lo = 0;
    hi = table_used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (lo < table_used && table_keys[lo] == key) begin
      if (table_counts[lo] != 32'hffff_ffff) table_counts[lo]++;
      expected_results.push_back(mk(8'h00, table_counts[lo], lo, 1'b0, 1'b0, 1'b1));
    end else if (table_used >= swft_pkg::DictEntries) begin
      expected_results.push_back(mk(8'h00, 0, 0, 1'b0, 1'b1, 1'b1));
    end else begin
      for (int i = table_used; i > lo; i--) begin
        table_keys[i] = table_keys[i-1];
        table_counts[i] = table_counts[i-1];
      end
      table_keys[lo] = key;
      table_counts[lo] = 1;
      table_used++;
      expected_results.push_back(mk(8'h00, 1, lo, 1'b1, 1'b0, 1'b1));
    end
  endtask

  // input side: prediction on each accepted transfer
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o)
      predict_transfer('{command_i, char_in_i, end_of_word_i, entry_index_i});
  end

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    item_t it;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
        it = pending_items.pop_front();
        command_i <= it.cmd;
        char_in_i <= it.ch;
        end_of_word_i <= it.eow;
        entry_index_i <= it.idx;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: ready changes on the falling edge, results checked on the rising edge
  always @(negedge clk_i) begin
    if (stall_req && !stall_done) begin
      if (stall_left == 0) stall_left <= 400;
      else if (stall_left == 1) stall_done <= 1'b1;
      if (stall_left != 1) out_ready_i <= 1'b0;
      else out_ready_i <= 1'b1;
      if (stall_left > 0) stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= rst_ni && (quiet || $urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected transfer, char_out", char_out_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (char_out_o !== want.ch) report("char_out", char_out_o, want.ch);
        if (count_o !== want.cnt) report("count", count_o, want.cnt);
        if (position_o !== want.pos) report("position", position_o, want.pos);
        if (new_word_o !== want.nw) report("new_word", new_word_o, want.nw);
        if (dropped_o !== want.dr) report("dropped", dropped_o, want.dr);
        if (entries_in_use_o !== want.used)
          report("entries_in_use", entries_in_use_o, want.used);
        if (last_o !== want.last) report("last", last_o, want.last);
      end
    end
  end

  task automatic push_char(input logic [7:0] c, input logic eow);
    pending_items.push_back('{swft_pkg::CmdChar, c, eow,
                              swft_pkg::IdxW'($urandom_range(1023))});
  endtask

  task automatic push_read(input int idx);
    pending_items.push_back('{swft_pkg::CmdRead, 8'($urandom), 1'($urandom),
                              idx[swft_pkg::IdxW-1:0]});
  endtask

  task automatic push_word(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    wait (pending_items.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    #20ms;
    $display("sorted_word_frequency_table_tb: FAIL");
    $finish;
  end

  initial begin
    string alpha;
    string punct;
    int n, k;
    alpha = "abcdeABCDE";
    punct = "!,.?;:'-";
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, no idling
    push_read(0);                 // read of an empty table
    push_word("Hello,");          // uppercase and trailing punctuation
    push_word("hello");
    push_word("!");               // empty after punctuation removal
    push_char(8'h61, 1'b0);       // zero byte ends the key
    push_char(8'h00, 1'b0);
    push_char(8'h62, 1'b1);
    push_char(8'hff, 1'b1);
    push_char(8'h00, 1'b1);
    push_char(8'h78, 1'b0);       // read in the middle of a word
    push_read(1);
    push_char(8'h79, 1'b1);
    push_word("abcdefghijklmnopqrstuvwxy");  // overlong word
    push_read(1023);
    wait_drained();
    for (int i = 0; i < table_used; i++) push_read(i);
    wait_drained();
    quiet = 1'b0;

    // random part; the receiver holds off for a long stretch in the middle
    n = 0;
    while (n < 240) begin
      if (n >= 120) stall_req = 1'b1;
      k = $urandom_range(99);
      if (k < 65) begin
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          logic [7:0] c;
          c = alpha[$urandom_range(alpha.len() - 1)];
          if (i == len - 1 && $urandom_range(3) == 0) c = punct[$urandom_range(punct.len() - 1)];
          push_char(c, i == len - 1);
          n++;
        end
      end else if (k < 88) begin
        push_read($urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(table_used + 2));
        n++;
      end else begin
        push_char(8'($urandom), $urandom_range(2) == 0);
        n++;
      end
    end
    push_char(8'h7a, 1'b1);       // close any open word
    wait_drained();

    push_word("\x7f\x7f\x7f");
    push_word("hello");
    push_read(1023);
    push_read(512);
    for (int i = 0; i < 5; i++) push_read($urandom_range(1023));
    wait_drained();

    if (mismatches == 0) begin
      $display("sorted_word_frequency_table_tb: PASS");
    end else begin
      $display("sorted_word_frequency_table_tb: FAIL");
    end
    $finish;
  end

endmodule
